FILE: src/btpa_pkg.sv
`timescale 1ns / 1ps
package btpa_pkg;

   localparam int POOL_UNITS = 1024;
   localparam int ADDR_W     = $clog2(POOL_UNITS);
   localparam int CNT_W      = ADDR_W + 1;

   // request kinds
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_NO_FIT  = 2'd1;
   localparam logic [1:0] STAT_BAD_REQ = 2'd2;

   // one write to the tag memories
   typedef struct packed {
      logic              used_we;
      logic              link_we;
      logic [ADDR_W-1:0] addr;
      logic              used;
      logic [ADDR_W-1:0] link;
   } tag_wr_type;

endpackage

FILE: src/btpa_ifs.sv
`timescale 1ns / 1ps
interface btpa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [btpa_pkg::CNT_W-1:0]  alloc_size;
   logic [btpa_pkg::ADDR_W-1:0] block_addr;

   modport source (output valid, req_type, alloc_size, block_addr, input ready);
   modport sink   (input valid, req_type, alloc_size, block_addr, output ready);
endinterface

interface btpa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [btpa_pkg::ADDR_W-1:0] result_addr;
   logic [btpa_pkg::CNT_W-1:0]  units_free;

   modport source (output valid, status, result_addr, units_free, input ready);
   modport sink   (input valid, status, result_addr, units_free, output ready);
endinterface

FILE: src/boundary_tag_pool_allocator.sv
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// req_chan  in   valid/ready   req_type, alloc_size, block_addr
// rsp_chan  out  valid/ready   status, result_addr, units_free
//
// alloc: rejected early, else rover tag read, first-fit walk, 2 or 4 tag writes, post
//   free: bad head tag rejected, else merges up then down; walk rate set by one tag ram read port
// reset: a clearing pass writes every tag entry before requests are taken
// stalls: one request at a time; the sequencer holds in its last state while the response
//   register is full, and a new request may start while the last response waits
module boundary_tag_pool_allocator (
   input logic      clock,
   input logic      reset,
   btpa_req_if.sink req_chan,
   btpa_rsp_if.source rsp_chan
);
   import btpa_pkg::*;

   // sequencer states
   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_AROV   = 5'd2;   // rover tag read back
   localparam logic [4:0] S_AWALK  = 5'd3;   // first-fit walk, one block a cycle
   localparam logic [4:0] S_AW1    = 5'd4;   // head of taken block
   localparam logic [4:0] S_AW2    = 5'd5;   // tail of taken block
   localparam logic [4:0] S_AW3    = 5'd6;   // head of remainder
   localparam logic [4:0] S_AW4    = 5'd7;   // tail of remainder
   localparam logic [4:0] S_FHEAD  = 5'd8;   // freed block head read back
   localparam logic [4:0] S_FU1    = 5'd9;   // clear used at head
   localparam logic [4:0] S_FU2    = 5'd10;  // clear used at tail, read upper neighbor
   localparam logic [4:0] S_FUP    = 5'd11;
   localparam logic [4:0] S_FUW1   = 5'd12;
   localparam logic [4:0] S_FUW2   = 5'd13;
   localparam logic [4:0] S_FLOISS = 5'd14;  // read lower neighbor tail
   localparam logic [4:0] S_FLO    = 5'd15;
   localparam logic [4:0] S_FLW1   = 5'd16;
   localparam logic [4:0] S_FLW2   = 5'd17;
   localparam logic [4:0] S_FIN    = 5'd18;

   localparam logic [ADDR_W-1:0] LAST_UNIT = ADDR_W'(POOL_UNITS - 1);

   logic [4:0]        st_ff, st_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] loc_ff, loc_in;     // block start (walk position or freed address)
   logic [ADDR_W-1:0] e_ff, e_in;         // block end
   logic [ADDR_W-1:0] old_ff, old_in;     // old end / neighbor end / neighbor start
   logic [CNT_W-1:0]  size_ff, size_in;
   logic              alloc_ff, alloc_in;
   logic [1:0]        stat_ff, stat_in;
   logic [ADDR_W-1:0] rover_ff, rover_in;
   logic [CNT_W-1:0]  free_ff, free_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_stat_ff, rsp_stat_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CNT_W-1:0]  rsp_free_ff, rsp_free_in;

   tag_wr_type        wr;
   logic [ADDR_W-1:0] rd_addr;
   logic              used_rd;
   logic [ADDR_W-1:0] link_rd;

   logic [CNT_W-1:0]  blk_len;
   logic              fit;
   logic [CNT_W-1:0]  nxt;
   logic [CNT_W-1:0]  e_calc;
   logic              req_acc;
   logic              rsp_load;

   btpa_tag_ram u_tag_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .used_rd (used_rd),
      .link_rd (link_rd)
   );

   // fit test on the tag read back for loc
   assign blk_len = {1'b0, link_rd} - {1'b0, loc_ff} + CNT_W'(1);
   assign fit     = !used_rd && (link_rd >= loc_ff) && (blk_len >= size_ff);
   assign nxt     = {1'b0, link_rd} + CNT_W'(1);
   assign e_calc  = {1'b0, loc_ff} + size_ff - CNT_W'(1);

   assign req_acc  = req_chan.valid && (st_ff == S_IDLE);
   assign rsp_load = (st_ff == S_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      st_in    = st_ff;
      clr_in   = clr_ff;
      loc_in   = loc_ff;
      e_in     = e_ff;
      old_in   = old_ff;
      size_in  = size_ff;
      alloc_in = alloc_ff;
      stat_in  = stat_ff;
      rover_in = rover_ff;
      free_in  = free_ff;
      rd_addr  = loc_ff;
      wr       = '0;

      unique case (st_ff)
         S_CLEAR: begin
            wr.used_we = 1'b1;
            wr.link_we = 1'b1;
            wr.addr    = clr_ff;
            wr.used    = 1'b0;
            wr.link    = (clr_ff == '0) ? LAST_UNIT : '0;
            clr_in     = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_UNIT) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               stat_in  = STAT_DONE;
               size_in  = req_chan.alloc_size;
               alloc_in = (req_chan.req_type == REQ_ALLOC);
               if (req_chan.req_type == REQ_ALLOC) begin
                  loc_in  = rover_ff;
                  rd_addr = rover_ff;
                  if (req_chan.alloc_size == '0) begin
                     stat_in = STAT_BAD_REQ;
                     st_in   = S_FIN;
                  end else if (req_chan.alloc_size > free_ff) begin
                     stat_in = STAT_NO_FIT;
                     st_in   = S_FIN;
                  end else begin
                     st_in = S_AROV;
                  end
               end else begin
                  loc_in  = req_chan.block_addr;
                  rd_addr = req_chan.block_addr;
                  st_in   = S_FHEAD;
               end
            end
         end
         S_AROV, S_AWALK: begin
            if (fit) begin
               e_in    = e_calc[ADDR_W-1:0];
               old_in  = link_rd;
               free_in = free_ff - size_ff;
               st_in   = S_AW1;
            end else if (st_ff == S_AROV) begin
               loc_in  = '0;
               rd_addr = '0;
               st_in   = S_AWALK;
            end else if (nxt <= {1'b0, loc_ff} || nxt >= CNT_W'(POOL_UNITS)) begin
               stat_in = STAT_NO_FIT;
               st_in   = S_FIN;
            end else begin
               loc_in  = nxt[ADDR_W-1:0];
               rd_addr = nxt[ADDR_W-1:0];
            end
         end
         S_AW1: begin
            wr = '{used_we: 1'b1, link_we: 1'b1, addr: loc_ff, used: 1'b1, link: e_ff};
            st_in = S_AW2;
         end
         S_AW2: begin
            wr = '{used_we: 1'b1, link_we: 1'b1, addr: e_ff, used: 1'b1, link: loc_ff};
            st_in = (e_ff != old_ff) ? S_AW3 : S_FIN;
         end
         S_AW3: begin
            wr = '{used_we: 1'b1, link_we: 1'b1, addr: e_ff + ADDR_W'(1), used: 1'b0,
                   link: old_ff};
            st_in = S_AW4;
         end
         S_AW4: begin
            wr = '{used_we: 1'b1, link_we: 1'b1, addr: old_ff, used: 1'b0,
                   link: e_ff + ADDR_W'(1)};
            rover_in = e_ff + ADDR_W'(1);
            st_in    = S_FIN;
         end
         S_FHEAD: begin
            if (!used_rd || link_rd < loc_ff) begin
               stat_in = STAT_BAD_REQ;
               st_in   = S_FIN;
            end else begin
               e_in    = link_rd;
               free_in = free_ff + blk_len;
               st_in   = S_FU1;
            end
         end
         S_FU1: begin
            wr.used_we = 1'b1;
            wr.addr    = loc_ff;
            st_in      = S_FU2;
         end
         S_FU2: begin
            wr.used_we = 1'b1;
            wr.addr    = e_ff;
            rd_addr    = e_ff + ADDR_W'(1);
            st_in      = (e_ff == LAST_UNIT) ? S_FLOISS : S_FUP;
         end
         S_FUP: begin
            if (!used_rd) begin
               old_in = link_rd;
               st_in  = S_FUW1;
            end else begin
               st_in = S_FLOISS;
            end
         end
         S_FUW1: begin
            wr.link_we = 1'b1;
            wr.addr    = loc_ff;
            wr.link    = old_ff;
            st_in      = S_FUW2;
         end
         S_FUW2: begin
            wr.link_we = 1'b1;
            wr.addr    = old_ff;
            wr.link    = loc_ff;
            if (rover_ff == e_ff + ADDR_W'(1)) begin
               rover_in = loc_ff;
            end
            e_in  = old_ff;
            st_in = S_FLOISS;
         end
         S_FLOISS: begin
            rd_addr = loc_ff - ADDR_W'(1);
            st_in   = (loc_ff == '0) ? S_FIN : S_FLO;
         end
         S_FLO: begin
            if (!used_rd) begin
               old_in = link_rd;
               st_in  = S_FLW1;
            end else begin
               st_in = S_FIN;
            end
         end
         S_FLW1: begin
            wr.link_we = 1'b1;
            wr.addr    = old_ff;
            wr.link    = e_ff;
            st_in      = S_FLW2;
         end
         S_FLW2: begin
            wr.link_we = 1'b1;
            wr.addr    = e_ff;
            wr.link    = old_ff;
            if (rover_ff == loc_ff) begin
               rover_in = old_ff;
            end
            st_in = S_FIN;
         end
         S_FIN: begin
            if (rsp_load) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // response register, loaded when the previous response has gone
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_free_in  = rsp_free_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_stat_in  = stat_ff;
         rsp_addr_in  = (alloc_ff && stat_ff == STAT_DONE) ? loc_ff : '0;
         rsp_free_in  = free_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_CLEAR;
         clr_ff       <= '0;
         rover_ff     <= '0;
         free_ff      <= CNT_W'(POOL_UNITS);
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         clr_ff       <= clr_in;
         rover_ff     <= rover_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      loc_ff      <= loc_in;
      e_ff        <= e_in;
      old_ff      <= old_in;
      size_ff     <= size_in;
      alloc_ff    <= alloc_in;
      stat_ff     <= stat_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_free_ff <= rsp_free_in;
   end

   assign req_chan.ready       = (st_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_stat_ff;
   assign rsp_chan.result_addr = rsp_addr_ff;
   assign rsp_chan.units_free  = rsp_free_ff;

`ifndef SYNTHESIS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= CNT_W'(POOL_UNITS))
      else $error("free count above pool size");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> st_ff != S_IDLE)
      else $error("accepted request did not start the sequencer");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CLEAR |-> !req_chan.ready)
      else $error("request taken during clearing pass");

   a_addr_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff != STAT_DONE |-> rsp_addr_ff == '0)
      else $error("nonzero address on failed request");
`endif

endmodule

FILE: src/btpa_tag_ram.sv
`timescale 1ns / 1ps
module btpa_tag_ram (
   input  logic                        clock,
   input  btpa_pkg::tag_wr_type        wr,
   input  logic [btpa_pkg::ADDR_W-1:0] rd_addr,
   output logic                        used_rd,
   output logic [btpa_pkg::ADDR_W-1:0] link_rd
);
   import btpa_pkg::*;

   logic              used_mem [POOL_UNITS];
   logic [ADDR_W-1:0] link_mem [POOL_UNITS];
   logic              used_rd_ff;
   logic [ADDR_W-1:0] link_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.used_we) begin
         used_mem[wr.addr] <= wr.used;
      end
      used_rd_ff <= used_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[wr.addr] <= wr.link;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   assign used_rd = used_rd_ff;
   assign link_rd = link_rd_ff;

endmodule

FILE: sim/btpa_tb_ifs.sv
`timescale 1ns / 1ps
package btpa_tb_types;
   import btpa_pkg::*;

   // one expected response
   typedef struct {
      logic [1:0]        status;
      logic [ADDR_W-1:0] result_addr;
      logic [CNT_W-1:0]  units_free;
   } alloc_rsp_type;
endpackage

FILE: sim/tb_boundary_tag_pool_allocator.sv
`timescale 1ns / 1ps
module tb_boundary_tag_pool_allocator;
   import btpa_pkg::*;
   import btpa_tb_types::*;

   localparam int WATCHDOG_LIMIT = 40000; // covers clearing pass and longest walk

   logic clock;
   logic reset;

   btpa_req_if req_chan ();
   btpa_rsp_if rsp_chan ();

   boundary_tag_pool_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the tag memories
   logic [ADDR_W-1:0] shadow_link [POOL_UNITS];
   logic              shadow_used [POOL_UNITS];
   int unsigned       shadow_rover;
   int unsigned       shadow_free;

   alloc_rsp_type pending_rsp [$];
   int unsigned live_blocks [$]; // starts of blocks currently allocated
   int          error_count;
   int          idle_cycles;
   bit          no_stall;       // long stretch with no idling on either side

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // predictor
   // -------------------------------------------------------------------------
   function automatic int unsigned tag_link(int unsigned i);
      if (i >= POOL_UNITS) return 0;
      return 32'(shadow_link[i]);
   endfunction

   function automatic bit tag_used(int unsigned i);
      return i < POOL_UNITS && shadow_used[i];
   endfunction

   function automatic bit block_fits(int unsigned s, int unsigned size);
      int unsigned e;
      if (s >= POOL_UNITS || tag_used(s)) return 0;
      e = tag_link(s);
      if (e < s) return 0;
      return (e - s + 1) >= size;
   endfunction

   function automatic void write_tag(int unsigned i, int unsigned link, bit used);
      if (i < POOL_UNITS) begin
         shadow_link[i] = ADDR_W'(link);
         shadow_used[i] = used;
      end
   endfunction

   function automatic void pool_clear();
      for (int i = 0; i < POOL_UNITS; i++) begin
         shadow_link[i] = '0;
         shadow_used[i] = 1'b0;
      end
      shadow_link[0] = ADDR_W'(POOL_UNITS - 1);
      shadow_rover   = 0;
      shadow_free    = POOL_UNITS;
   endfunction

   // applies one request to the shadow pool, returns the expected response
   function automatic alloc_rsp_type pool_apply(logic kind, int unsigned size,
                                                int unsigned addr);
      alloc_rsp_type r;
      bit          found;
      int unsigned loc, steps, nxt, e, old_end, up, up_end, pstart;
      r.status = STAT_DONE;
      r.result_addr = '0;
      found = 0;
      loc = 0;
      if (kind == REQ_ALLOC) begin
         if (size == 0) r.status = STAT_BAD_REQ;
         else if (size > shadow_free) r.status = STAT_NO_FIT;
         else begin
            // rover first, then first-fit walk from the bottom
            if (block_fits(shadow_rover, size)) begin
               loc = shadow_rover;
               found = 1;
            end else begin
               steps = 0;
               while (loc < POOL_UNITS && steps < POOL_UNITS) begin
                  if (block_fits(loc, size)) begin
                     found = 1;
                     break;
                  end
                  nxt = tag_link(loc) + 1;
                  if (nxt <= loc) break;
                  loc = nxt;
                  steps++;
               end
            end
            if (found) begin
               old_end = tag_link(loc);
               e = loc + size - 1;
               write_tag(loc, e, 1'b1);
               write_tag(e, loc, 1'b1);
               shadow_free -= size;
               // split off the remainder, which becomes the rover
               if (e != old_end) begin
                  write_tag(e + 1, old_end, 1'b0);
                  write_tag(old_end, e + 1, 1'b0);
                  shadow_rover = e + 1;
               end
               r.result_addr = ADDR_W'(loc);
            end else r.status = STAT_NO_FIT;
         end
      end else begin
         e = tag_link(addr);
         if (!tag_used(addr) || e < addr) r.status = STAT_BAD_REQ;
         else begin
            shadow_used[addr] = 1'b0;
            shadow_used[e] = 1'b0;
            shadow_free += e - addr + 1;
            // merge with the free block above
            if (e + 1 < POOL_UNITS && !tag_used(e + 1)) begin
               up = e + 1;
               up_end = tag_link(up);
               shadow_link[addr] = ADDR_W'(up_end);
               shadow_link[up_end] = ADDR_W'(addr);
               if (shadow_rover == up) shadow_rover = addr;
               e = up_end;
            end
            // merge with the free block below, never at address zero
            if (addr > 0 && !tag_used(addr - 1)) begin
               pstart = tag_link(addr - 1);
               shadow_link[pstart] = ADDR_W'(e);
               shadow_link[e] = ADDR_W'(pstart);
               if (shadow_rover == addr) shadow_rover = pstart;
            end
         end
      end
      r.units_free = CNT_W'(shadow_free);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // request driver
   // -------------------------------------------------------------------------
   // valid stays high after an accept until the next request or an idle cycle
   task automatic send_request(logic kind, int unsigned size, int unsigned addr);
      alloc_rsp_type r;
      while (!no_stall && $urandom_range(99) < 10) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.alloc_size <= size[CNT_W-1:0];
      req_chan.block_addr <= addr[ADDR_W-1:0];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // accepted at this edge: update shadow state and book-keep allocated starts
      r = pool_apply(kind, size, addr);
      pending_rsp.push_back(r);
      if (kind == REQ_ALLOC && r.status == STAT_DONE)
         live_blocks.push_back(32'(r.result_addr));
      if (kind == REQ_FREE && r.status == STAT_DONE)
         foreach (live_blocks[i])
            if (live_blocks[i] == addr) begin
               live_blocks.delete(i);
               break;
            end
   endtask

   task automatic alloc_req(int unsigned size);
      send_request(REQ_ALLOC, size, $urandom_range(POOL_UNITS - 1));
   endtask

   task automatic free_req(int unsigned addr);
      send_request(REQ_FREE, $urandom_range(2047), addr);
   endtask

   // free a random live block, or a junk address if none
   task automatic free_random_live();
      int unsigned k;
      if (live_blocks.size() == 0) free_req($urandom_range(POOL_UNITS - 1));
      else begin
         k = $urandom_range(live_blocks.size() - 1);
         free_req(live_blocks[k]);
      end
   endtask

   // -------------------------------------------------------------------------
   // response checker and ready generator
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= no_stall || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with none expected");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_chan.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.result_addr !== e.result_addr) begin
               $error("result_addr expected %0d actual %0d", e.result_addr,
                      rsp_chan.result_addr);
               error_count++;
            end
            if (rsp_chan.units_free !== e.units_free) begin
               $error("units_free expected %0d actual %0d", e.units_free,
                      rsp_chan.units_free);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("boundary_tag_pool_allocator test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   // zero size, oversize, full pool, single unit blocks, bad frees
   task automatic test_directed();
      alloc_req(0);
      alloc_req(2047);
      alloc_req(1025);
      free_req(0);                 // free of a free block
      alloc_req(1);                // one-unit block at 0
      alloc_req(POOL_UNITS - 2);   // fits in remainder via rover, one unit left
      alloc_req(1);                // last unit, one-unit block
      alloc_req(1);                // pool empty
      free_req(POOL_UNITS - 1);    // last unit, no upper merge
      free_req(5);                 // interior of a used block
      free_req(POOL_UNITS - 1);    // double free
      free_req(1);                 // merge with free block above
      free_req(0);                 // bottom, no lower merge, merges up
      alloc_req(POOL_UNITS);       // whole pool
      free_req(0);
      alloc_req(10);
      alloc_req(20);
      alloc_req(30);
      free_req(10);                // middle: merges nowhere
      free_req(0);                 // merges up
      alloc_req(25);               // rover block fits, free block at 0 unused
      free_req(30);                // upper neighbor used: merges down only
      free_req(0);
      alloc_req(1023);
      free_req(0);
   endtask

   // mostly well-formed alloc/free traffic with random sizes, some noise
   task automatic test_random(int unsigned count);
      int unsigned sel;
      for (int unsigned n = 0; n < count; n++) begin
         no_stall = (n >= count / 2) && (n < count / 2 + 150);
         sel = $urandom_range(99);
         if (sel < 45) begin
            // mostly small sizes, a few huge ones
            if ($urandom_range(19) == 0) alloc_req($urandom_range(2047));
            else alloc_req($urandom_range(64, 1));
         end else if (sel < 88) free_random_live();
         else if (sel < 94) free_req($urandom_range(POOL_UNITS - 1));
         else alloc_req(0);
      end
      no_stall = 0;
      // drain every live block so the pool coalesces back
      while (live_blocks.size() > 0) free_random_live();
      alloc_req(POOL_UNITS);
   endtask

   initial begin
      reset = 1'b1;
      no_stall = 0;
      error_count = 0;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= REQ_ALLOC;
      req_chan.alloc_size <= '0;
      req_chan.block_addr <= '0;
      pool_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(1200);
      req_chan.valid <= 1'b0;

      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("boundary_tag_pool_allocator test passed");
      else $display("boundary_tag_pool_allocator test failed");
      $finish;
   end

endmodule

FILE: files.f
src/btpa_pkg.sv
src/btpa_ifs.sv
src/btpa_tag_ram.sv
src/boundary_tag_pool_allocator.sv
sim/btpa_tb_ifs.sv
sim/tb_boundary_tag_pool_allocator.sv
